// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the bit reader modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSBR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MSBR_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MSBR_ASSERT(name, prop, msg)
`define MSBR_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ===== hw/rtl/msbr_pkg.sv =====
// types and constants of the msb-first bit reader
package msbr_pkg;

  localparam int unsigned STORE_BYTES_DEF = 64;
  localparam int unsigned STORE_BYTES_MAX = 8192;
  localparam int unsigned SLOT_W          = $clog2(STORE_BYTES_MAX);
  localparam int unsigned COUNT_W         = 16;
  localparam int unsigned MAX_READ_BITS   = 32;
  localparam int unsigned CNT_W           = $clog2(MAX_READ_BITS + 1);
  localparam int unsigned BYTE_BITS       = 8;
  localparam int unsigned NUM_BANKS       = 4;
  localparam int unsigned LANE_W          = $clog2(NUM_BANKS);
  localparam int unsigned WINDOW_BITS     = (NUM_BANKS + 1) * BYTE_BITS;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned AVAIL_W         = 10;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_SKIP  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_BAD_COUNT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] bit_count;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        read_value;
    logic [AVAIL_W-1:0] bits_available;
    logic               byte_aligned;
    logic [3:0]         bits_to_boundary;
  } rsp_t;

  // work handed from the front part to the back part
  typedef struct packed {
    cmd_e              kind;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        data;
    logic [2:0]        off;
    logic [CNT_W-1:0]  cnt;
    rsp_t              rsp;
  } cmd_t;

endpackage

// ===== hw/rtl/msbr_ram.sv =====
// generic single write port ram with registered read
module msbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/msbr_front.sv =====
// front part: keeps the read and write position and classifies each request
`include "assert_macros.svh"
module msbr_front #(
  parameter int unsigned STORE_BYTES = msbr_pkg::STORE_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  msbr_pkg::req_t  req_i,
  output logic            cmd_valid_o,
  output msbr_pkg::cmd_t  cmd_o,
  input  logic            cmd_ready_i
);

  localparam int unsigned IDX_W  = $clog2(STORE_BYTES);
  localparam int unsigned FILL_W = $clog2(STORE_BYTES + 1);
  localparam int unsigned HELD_W = FILL_W + 3;
  localparam int unsigned CMP_W  = (HELD_W > msbr_pkg::COUNT_W) ? HELD_W : msbr_pkg::COUNT_W;
  localparam int unsigned TOT_W  = msbr_pkg::COUNT_W + 1;

  logic [IDX_W-1:0]  ri_q, ri_d, wi_q, wi_d, wi_inc, adv_idx, wi_exp;
  logic [FILL_W-1:0] fill_q, fill_d, adv_fill, adv_whole;
  logic [2:0]        off_q, off_d, adv_off;
  logic [HELD_W-1:0] held, held_d;
  logic              under, store_full, accept;
  logic [TOT_W-1:0]  total;
  logic [FILL_W:0]   idx_sum, exp_sum;

  assign accept     = req_valid_i && cmd_ready_i;
  assign held       = {fill_q, 3'b000} - HELD_W'(off_q);
  assign under      = CMP_W'(req_i.bit_count) > CMP_W'(held);
  assign store_full = fill_q == FILL_W'(STORE_BYTES);
  assign wi_inc     = (wi_q == IDX_W'(STORE_BYTES - 1)) ? '0 : wi_q + 1'b1;

  // position after consuming bit_count bits
  assign total     = TOT_W'(off_q) + TOT_W'(req_i.bit_count);
  assign adv_whole = FILL_W'(total[TOT_W-1:3]);
  assign adv_fill  = fill_q - adv_whole;
  assign adv_off   = (adv_fill == '0) ? 3'd0 : total[2:0];
  assign idx_sum   = (FILL_W + 1)'(ri_q) + (FILL_W + 1)'(adv_whole);
  assign adv_idx   = (idx_sum >= (FILL_W + 1)'(STORE_BYTES))
                   ? IDX_W'(idx_sum - (FILL_W + 1)'(STORE_BYTES)) : IDX_W'(idx_sum);

  always_comb begin
    ri_d   = ri_q;
    wi_d   = wi_q;
    fill_d = fill_q;
    off_d  = off_q;
    cmd_o  = '0;
    cmd_o.kind       = msbr_pkg::CMD_NONE;
    cmd_o.rsp.status = msbr_pkg::ST_OK;
    case (msbr_pkg::req_e'(req_i.req_type))
      msbr_pkg::REQ_PUSH: begin
        if (store_full) begin
          cmd_o.rsp.status = msbr_pkg::ST_OVERFLOW;
        end else begin
          cmd_o.kind = msbr_pkg::CMD_WRITE;
          cmd_o.slot = msbr_pkg::SLOT_W'(wi_q);
          cmd_o.data = req_i.data_byte;
          wi_d       = wi_inc;
          fill_d     = fill_q + 1'b1;
        end
      end
      msbr_pkg::REQ_READ: begin
        if (req_i.bit_count > msbr_pkg::COUNT_W'(msbr_pkg::MAX_READ_BITS)) begin
          cmd_o.rsp.status = msbr_pkg::ST_BAD_COUNT;
        end else if (under) begin
          cmd_o.rsp.status = msbr_pkg::ST_UNDERFLOW;
        end else begin
          ri_d   = adv_idx;
          fill_d = adv_fill;
          off_d  = adv_off;
          if (req_i.bit_count != '0) begin
            cmd_o.kind = msbr_pkg::CMD_READ;
            cmd_o.slot = msbr_pkg::SLOT_W'(ri_q);
            cmd_o.off  = off_q;
            cmd_o.cnt  = msbr_pkg::CNT_W'(req_i.bit_count);
          end
        end
      end
      msbr_pkg::REQ_SKIP: begin
        if (under) begin
          cmd_o.rsp.status = msbr_pkg::ST_UNDERFLOW;
        end else begin
          ri_d   = adv_idx;
          fill_d = adv_fill;
          off_d  = adv_off;
        end
      end
      msbr_pkg::REQ_CLEAR: begin
        ri_d   = '0;
        wi_d   = '0;
        fill_d = '0;
        off_d  = '0;
      end
      default: begin
        cmd_o.kind = msbr_pkg::CMD_NONE;
      end
    endcase
    held_d = {fill_d, 3'b000} - HELD_W'(off_d);
    cmd_o.rsp.bits_available   = msbr_pkg::AVAIL_W'(held_d);
    cmd_o.rsp.byte_aligned     = off_d == 3'd0;
    cmd_o.rsp.bits_to_boundary = 4'(msbr_pkg::BYTE_BITS) - 4'(off_d);
  end

  assign cmd_valid_o = req_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q   <= '0;
      wi_q   <= '0;
      fill_q <= '0;
      off_q  <= '0;
    end else if (accept) begin
      ri_q   <= ri_d;
      wi_q   <= wi_d;
      fill_q <= fill_d;
      off_q  <= off_d;
    end
  end

  // write slot always sits fill_count bytes past the read slot
  assign exp_sum = (FILL_W + 1)'(ri_q) + (FILL_W + 1)'(fill_q);
  assign wi_exp  = (exp_sum >= (FILL_W + 1)'(STORE_BYTES))
                 ? IDX_W'(exp_sum - (FILL_W + 1)'(STORE_BYTES)) : IDX_W'(exp_sum);

  `MSBR_ASSERT(a_wi_tracks_fill, wi_q == wi_exp, "write slot out of step with fill count")
  `MSBR_ASSERT(a_off_needs_byte, off_q != 3'd0 |-> fill_q != '0, "bit offset in empty store")
  `MSBR_ASSERT_NEVER(a_fill_range, fill_q > FILL_W'(STORE_BYTES), "fill count above store size")

endmodule

// ===== hw/rtl/msbr_fifo.sv =====
// short command queue between the front and back parts
`include "assert_macros.svh"
module msbr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  msbr_pkg::cmd_t  wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_pop_i,
  output msbr_pkg::cmd_t  rd_data_o
);

  localparam int unsigned DEPTH = msbr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  msbr_pkg::cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign wr_ready_o = cnt_q != CNT_W'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `MSBR_ASSERT(a_ptrs_meet, cnt_q == '0 |-> wr_ptr_q == rd_ptr_q, "empty queue with split pointers")

endmodule

// ===== hw/rtl/msbr_back.sv =====
// back part: banked byte store, two-phase fetch and bit extraction
`include "assert_macros.svh"
module msbr_back #(
  parameter int unsigned STORE_BYTES = msbr_pkg::STORE_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  msbr_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  output logic            rsp_valid_o,
  output msbr_pkg::rsp_t  rsp_o,
  input  logic            rsp_pop_i
);

  localparam int unsigned NB     = msbr_pkg::NUM_BANKS;
  localparam int unsigned LW     = msbr_pkg::LANE_W;
  localparam int unsigned ROWS   = STORE_BYTES / NB;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned IDX_W  = $clog2(STORE_BYTES);
  localparam int unsigned WIN_W  = msbr_pkg::WINDOW_BITS;
  localparam int unsigned SH_W   = $clog2(WIN_W + 1);
  localparam int unsigned WORD_W = NB * msbr_pkg::BYTE_BITS;

  logic             advance, is_read, is_write;
  logic             phase_q, phase_d;
  logic [IDX_W-1:0] slot;
  logic [LW-1:0]    lane, s1_lane;
  logic [ROW_W-1:0] row, row_nx;

  logic [NB-1:0]    bank_we, bank_re;
  logic [ROW_W-1:0] bank_raddr [NB];
  logic [7:0]       bank_rd    [NB];

  logic             s1_valid_q;
  msbr_pkg::cmd_t   s1_cmd_q;
  logic [WORD_W-1:0] s1_win_q, win_d;

  logic             out_valid_q;
  msbr_pkg::rsp_t   out_q, out_d;
  logic [WIN_W-1:0] window, shifted;
  logic [SH_W-1:0]  sh;
  logic [32:0]      mask_hi;

  // the whole back pipeline moves in lockstep so bank outputs stay put
  assign advance  = !out_valid_q || rsp_pop_i;
  assign is_read  = cmd_valid_i && (cmd_i.kind == msbr_pkg::CMD_READ);
  assign is_write = cmd_valid_i && (cmd_i.kind == msbr_pkg::CMD_WRITE);
  assign cmd_pop_o = advance && cmd_valid_i && (!is_read || phase_q);
  assign phase_d   = (advance && is_read) ? !phase_q : phase_q;

  assign slot   = IDX_W'(cmd_i.slot);
  assign lane   = slot[LW-1:0];
  assign row    = ROW_W'(slot >> LW);
  assign row_nx = (row == ROW_W'(ROWS - 1)) ? '0 : row + 1'b1;

  for (genvar b = 0; b < NB; b++) begin : g_bank
    // first phase fetches four consecutive bytes, second phase the fifth
    assign bank_re[b]    = advance && is_read && (!phase_q || lane == LW'(b));
    assign bank_raddr[b] = (phase_q || LW'(b) < lane) ? row_nx : row;
    assign bank_we[b]    = advance && is_write && lane == LW'(b);

    msbr_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (row),
      .wdata_i (cmd_i.data),
      .re_i    (bank_re[b]),
      .raddr_i (bank_raddr[b]),
      .rdata_o (bank_rd[b])
    );
  end

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      win_d[WORD_W-1-8*j -: 8] = bank_rd[LW'(lane + LW'(j))];
    end
  end

  // extract cnt bits starting off bits into the five byte window
  assign s1_lane = s1_cmd_q.slot[LW-1:0];
  assign window  = {s1_win_q, bank_rd[s1_lane]};
  assign sh      = SH_W'(WIN_W) - SH_W'(s1_cmd_q.off) - SH_W'(s1_cmd_q.cnt);
  assign shifted = window >> sh;
  assign mask_hi = {33{1'b1}} << s1_cmd_q.cnt;

  always_comb begin
    out_d = s1_cmd_q.rsp;
    if (s1_cmd_q.kind == msbr_pkg::CMD_READ) begin
      out_d.read_value = shifted[31:0] & ~mask_hi[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (advance) begin
        s1_valid_q  <= cmd_pop_o;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_cmd_q <= cmd_i;
      s1_win_q <= win_d;
      out_q    <= out_d;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  `MSBR_ASSERT(a_phase_on_read, phase_q |-> is_read, "second fetch phase without a read at head")
  `MSBR_ASSERT_NEVER(a_write_in_stall, !advance && (|bank_we), "store write while pipeline stalled")

endmodule

// ===== hw/rtl/msb_first_bit_reader.sv =====
// msb-first bit reader: banked circular byte store with bit read and skip
//
// input channel: push/full carries one request (push byte, read bits, skip bits,
// clear); it is taken on a clock edge with push high and full low. output channel:
// empty/pop; the oldest result sits on rsp_o while empty is low and is taken on an
// edge with pop high. every request gives exactly one result, in order.
// path: each result passes the command queue, the fetch stage register and the
// output register; a read of 1 to 32 bits also waits for its second fetch phase.
// throughput: one request per cycle unless pop holds the back end, but a read of 1 to
// 32 bits takes a first and a second fetch phase there: its five window bytes span
// four byte banks of one read port each: four bytes come in the first, the fifth later.
// a two-entry command queue sits between the classifying front end and the
// fetching back end; when pop stays low the back end holds, the queue fills and
// full rises, and nothing is lost.
// reset empties the store and zeroes all positions; store contents are not
// cleared and need no clearing pass. STORE_BYTES must be a multiple of four.
module msb_first_bit_reader #(
  parameter int unsigned STORE_BYTES = msbr_pkg::STORE_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  msbr_pkg::req_t  req_i,
  output logic            empty,
  input  logic            pop,
  output msbr_pkg::rsp_t  rsp_o
);

  logic           front_valid, q_ready, q_valid, q_pop, rsp_valid;
  msbr_pkg::cmd_t front_cmd, q_cmd;

  msbr_front #(
    .STORE_BYTES (STORE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (push),
    .req_i       (req_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (q_ready)
  );

  msbr_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (q_ready),
    .wr_data_i  (front_cmd),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_data_o  (q_cmd)
  );

  msbr_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp_o),
    .rsp_pop_i   (pop)
  );

  assign full  = !q_ready;
  assign empty = !rsp_valid;

endmodule
